// ===== rtl/vcsdm_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers for the voxel chunk store
// no dependencies

package vcsdm_pkg;

	localparam int CHUNK_WIDTH  = 16;
	localparam int CHUNK_HEIGHT = 16;
	localparam int CHUNK_DEPTH  = 16;
	localparam int MAX_CHUNKS_X = 4;
	localparam int MAX_CHUNKS_Y = 4;
	localparam int MAX_CHUNKS_Z = 4;

	localparam int SKY_OPEN    = 15;
	localparam int CFG_RESET   = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam int CHUNK_CELLS = CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_DEPTH;
	localparam int MAX_CHUNKS  = MAX_CHUNKS_X * MAX_CHUNKS_Y * MAX_CHUNKS_Z;
	localparam int STORE_DEPTH = MAX_CHUNKS * CHUNK_CELLS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int MAX_DIM_XY = (MAX_CHUNKS_X > MAX_CHUNKS_Y) ? MAX_CHUNKS_X : MAX_CHUNKS_Y;
	localparam int MAX_DIM    = (MAX_DIM_XY > MAX_CHUNKS_Z) ? MAX_DIM_XY : MAX_CHUNKS_Z;
	localparam int CNT_W      = $clog2(MAX_DIM + 1);
	localparam int CC_W       = $clog2(MAX_DIM);

	localparam int MAX_CELL_XY = (CHUNK_WIDTH > CHUNK_HEIGHT) ? CHUNK_WIDTH : CHUNK_HEIGHT;
	localparam int MAX_CELL    = (MAX_CELL_XY > CHUNK_DEPTH) ? MAX_CELL_XY : CHUNK_DEPTH;
	localparam int LOC_W       = $clog2(MAX_CELL);

	localparam int CMD_W     = 3;
	localparam int POS_W     = 8;
	localparam int BLOCK_W   = 8;
	localparam int LIGHT_W   = 4;
	localparam int QUERY_W   = 6;
	localparam int LIN_W     = 6;
	localparam int DIRTY_W   = $clog2(MAX_CHUNKS);
	localparam int CFG_W     = 3;
	localparam int CFG_IDX_W = 2;

	localparam int IN_FIELDS_W  = 3 * POS_W + BLOCK_W + LIGHT_W + QUERY_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = BLOCK_W + LIGHT_W + LIN_W + 1;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_USER_W   = 2;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_GET_BLOCK = 3'd0,
		CMD_SET_BLOCK = 3'd1,
		CMD_GET_LIGHT = 3'd2,
		CMD_SET_LIGHT = 3'd3,
		CMD_DIRTY     = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NX = 2'd0,
		CFG_NY = 2'd1,
		CFG_NZ = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_GET_BLOCK,
		OP_GET_LIGHT,
		OP_SKY,
		OP_SET_BLOCK,
		OP_SET_LIGHT,
		OP_ERROR,
		OP_DIRTY
	} op_kind_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_MARK
	} bk_state_t;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CC_W-1:0]  ccoord_t;

	typedef struct packed {
		cnt_t nx;
		cnt_t ny;
		cnt_t nz;
	} world_size_t;

	typedef struct packed {
		ccoord_t base;
		logic    two;
	} axis_span_t;

	typedef struct packed {
		op_kind_t           kind;
		logic [ADDR_W-1:0]  addr;
		logic [BLOCK_W-1:0] data;
		axis_span_t         span_x;
		axis_span_t         span_y;
		axis_span_t         span_z;
		logic [QUERY_W-1:0] query;
		logic               q_ok;
	} op_t;

	typedef struct packed {
		logic               last;
		logic               dirty;
		logic [LIN_W-1:0]   marked_chunk;
		logic               marked_valid;
		logic               bounds_error;
		logic [LIGHT_W-1:0] light;
		logic [BLOCK_W-1:0] block;
	} res_t;

	function automatic cnt_t eff_size(input logic [CFG_W-1:0] raw, input int maxv);
		cnt_t r;
		if (raw == '0) begin
			r = cnt_t'(1);
		end else if (int'(raw) > maxv) begin
			r = cnt_t'(maxv);
		end else begin
			r = cnt_t'(raw);
		end
		return r;
	endfunction

endpackage

// ===== rtl/voxel_chunk_store_dirty_mark_top.sv =====
`timescale 1ns / 1ps
// in-world get block/light: store read into a register, output loaded in BK_READ;
// dirty query, set light, out-of-world gets and errors: output loaded from idle;
// set block: store written, then one BK_MARK result per marked chunk (up to 8);
// items pop only in idle; a 2-entry queue lets input accept while back end or output stall
// reset: sizes return to 4, all dirty flags set, then a clearing pass writes zero to all
// 262144 block and light entries while no item is accepted
// top level; depends on vcsdm_pkg, vcsdm_front, vcsdm_queue, vcsdm_back

module voxel_chunk_store_dirty_mark_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [vcsdm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vcsdm_pkg::CFG_W-1:0]        cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// pos_x, pos_y, pos_z, new_block, new_light, query_chunk, zero fill
	input  logic [vcsdm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// cmd
	input  logic [vcsdm_pkg::CMD_W-1:0]        s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// block_out, light_out, marked_chunk, dirty_out, zero fill
	output logic [vcsdm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// bounds_error, marked_valid
	output logic [vcsdm_pkg::OUT_USER_W-1:0]   m_axis_tuser,
	output logic                               m_axis_tlast
);

	logic [vcsdm_pkg::CFG_W-1:0] cfg_x_q, cfg_y_q, cfg_z_q;
	vcsdm_pkg::world_size_t size;
	logic           clear_done;
	logic           push_valid, push_ready, pop_valid, pop_ready;
	vcsdm_pkg::op_t push_op, pop_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_x_q <= vcsdm_pkg::CFG_W'(vcsdm_pkg::CFG_RESET);
			cfg_y_q <= vcsdm_pkg::CFG_W'(vcsdm_pkg::CFG_RESET);
			cfg_z_q <= vcsdm_pkg::CFG_W'(vcsdm_pkg::CFG_RESET);
		end else if (cfg_we) begin
			case (vcsdm_pkg::cfg_index_t'(cfg_index))
				vcsdm_pkg::CFG_NX: begin
					cfg_x_q <= cfg_data;
				end
				vcsdm_pkg::CFG_NY: begin
					cfg_y_q <= cfg_data;
				end
				vcsdm_pkg::CFG_NZ: begin
					cfg_z_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign size.nx = vcsdm_pkg::eff_size(cfg_x_q, vcsdm_pkg::MAX_CHUNKS_X);
	assign size.ny = vcsdm_pkg::eff_size(cfg_y_q, vcsdm_pkg::MAX_CHUNKS_Y);
	assign size.nz = vcsdm_pkg::eff_size(cfg_z_q, vcsdm_pkg::MAX_CHUNKS_Z);

	vcsdm_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.size          (size),
		.enable        (clear_done),
		.push_valid    (push_valid),
		.push_op       (push_op),
		.push_ready    (push_ready)
	);

	vcsdm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop_ready  (pop_ready)
	);

	vcsdm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.size          (size),
		.pop_valid     (pop_valid),
		.pop_op        (pop_op),
		.pop_ready     (pop_ready),
		.clear_done    (clear_done),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== rtl/vcsdm_front.sv =====
`timescale 1ns / 1ps
// front end: takes input items, checks bounds, forms the cell address and neighbor spans
// depends on vcsdm_pkg

module vcsdm_front (
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// pos_x, pos_y, pos_z, new_block, new_light, query_chunk, zero fill
	input  logic [vcsdm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// cmd
	input  logic [vcsdm_pkg::CMD_W-1:0]        s_axis_tuser,
	input  vcsdm_pkg::world_size_t             size,
	input  logic                               enable,
	output logic                               push_valid,
	output vcsdm_pkg::op_t                     push_op,
	input  logic                               push_ready
);

	localparam int P = vcsdm_pkg::POS_W;
	localparam int B = vcsdm_pkg::BLOCK_W;
	localparam int L = vcsdm_pkg::LIGHT_W;
	localparam int Q = vcsdm_pkg::QUERY_W;
	localparam int CC = vcsdm_pkg::CC_W;
	localparam int LW = vcsdm_pkg::LOC_W;
	localparam int CN = vcsdm_pkg::CNT_W;

	logic [P-1:0] px, py, pz;
	logic [B-1:0] new_block;
	logic [L-1:0] new_light;
	logic [Q-1:0] query;
	logic [P:0]   lim_x, lim_y, lim_z;
	logic         in_x, in_y, in_z, in_world;
	logic [CC-1:0] cx, cy, cz;
	logic [LW-1:0] lx, ly, lz;
	logic         lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	logic [Q:0]   n_chunks;
	vcsdm_pkg::op_kind_t kind;

	assign px        = s_axis_tdata[P-1:0];
	assign py        = s_axis_tdata[2*P-1:P];
	assign pz        = s_axis_tdata[3*P-1:2*P];
	assign new_block = s_axis_tdata[3*P+B-1:3*P];
	assign new_light = s_axis_tdata[3*P+B+L-1:3*P+B];
	assign query     = s_axis_tdata[3*P+B+L+Q-1:3*P+B+L];

	assign lim_x = (P+1)'(int'(size.nx) * vcsdm_pkg::CHUNK_WIDTH);
	assign lim_y = (P+1)'(int'(size.ny) * vcsdm_pkg::CHUNK_HEIGHT);
	assign lim_z = (P+1)'(int'(size.nz) * vcsdm_pkg::CHUNK_DEPTH);

	assign in_x     = !px[P-1] && ({1'b0, px} < lim_x);
	assign in_y     = !py[P-1] && ({1'b0, py} < lim_y);
	assign in_z     = !pz[P-1] && ({1'b0, pz} < lim_z);
	assign in_world = in_x && in_y && in_z;

	assign cx = CC'(px / vcsdm_pkg::CHUNK_WIDTH);
	assign cy = CC'(py / vcsdm_pkg::CHUNK_HEIGHT);
	assign cz = CC'(pz / vcsdm_pkg::CHUNK_DEPTH);
	assign lx = LW'(px % vcsdm_pkg::CHUNK_WIDTH);
	assign ly = LW'(py % vcsdm_pkg::CHUNK_HEIGHT);
	assign lz = LW'(pz % vcsdm_pkg::CHUNK_DEPTH);

	// neighbor chunk below or above along each axis, when it lies in the world
	assign lo_x = (lx == '0) && (cx != '0);
	assign lo_y = (ly == '0) && (cy != '0);
	assign lo_z = (lz == '0) && (cz != '0);
	assign hi_x = (lx == LW'(vcsdm_pkg::CHUNK_WIDTH - 1)) && ((CN'(cx) + CN'(1)) < size.nx);
	assign hi_y = (ly == LW'(vcsdm_pkg::CHUNK_HEIGHT - 1)) && ((CN'(cy) + CN'(1)) < size.ny);
	assign hi_z = (lz == LW'(vcsdm_pkg::CHUNK_DEPTH - 1)) && ((CN'(cz) + CN'(1)) < size.nz);

	assign n_chunks = (Q+1)'(int'(size.nx) * int'(size.ny) * int'(size.nz));

	always_comb begin
		case (vcsdm_pkg::cmd_t'(s_axis_tuser))
			vcsdm_pkg::CMD_GET_BLOCK: begin
				kind = in_world ? vcsdm_pkg::OP_GET_BLOCK : vcsdm_pkg::OP_NONE;
			end
			vcsdm_pkg::CMD_SET_BLOCK: begin
				kind = in_world ? vcsdm_pkg::OP_SET_BLOCK : vcsdm_pkg::OP_ERROR;
			end
			vcsdm_pkg::CMD_GET_LIGHT: begin
				kind = in_world ? vcsdm_pkg::OP_GET_LIGHT : vcsdm_pkg::OP_SKY;
			end
			vcsdm_pkg::CMD_SET_LIGHT: begin
				kind = in_world ? vcsdm_pkg::OP_SET_LIGHT : vcsdm_pkg::OP_ERROR;
			end
			vcsdm_pkg::CMD_DIRTY: begin
				kind = vcsdm_pkg::OP_DIRTY;
			end
			default: begin
				kind = vcsdm_pkg::OP_NONE;
			end
		endcase
	end

	always_comb begin
		push_op.kind = kind;
		push_op.addr = vcsdm_pkg::ADDR_W'(
			(((int'(cz) * vcsdm_pkg::MAX_CHUNKS_Y + int'(cy)) * vcsdm_pkg::MAX_CHUNKS_X
			+ int'(cx)) * vcsdm_pkg::CHUNK_CELLS)
			+ ((int'(lz) * vcsdm_pkg::CHUNK_HEIGHT + int'(ly)) * vcsdm_pkg::CHUNK_WIDTH
			+ int'(lx)));
		push_op.data = (kind == vcsdm_pkg::OP_SET_LIGHT) ? B'(new_light) : new_block;
		push_op.span_x.base = lo_x ? cx - CC'(1) : cx;
		push_op.span_x.two  = lo_x || hi_x;
		push_op.span_y.base = lo_y ? cy - CC'(1) : cy;
		push_op.span_y.two  = lo_y || hi_y;
		push_op.span_z.base = lo_z ? cz - CC'(1) : cz;
		push_op.span_z.two  = lo_z || hi_z;
		push_op.query = query;
		push_op.q_ok  = ({1'b0, query} < n_chunks) && (int'(query) < vcsdm_pkg::MAX_CHUNKS);
	end

	assign push_valid    = s_axis_tvalid && enable;
	assign s_axis_tready = push_ready && enable;

endmodule

// ===== rtl/vcsdm_queue.sv =====
`timescale 1ns / 1ps
// short queue of classified items between front and back end
// depends on vcsdm_pkg

module vcsdm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  vcsdm_pkg::op_t push_op,
	output logic           push_ready,
	output logic           pop_valid,
	output vcsdm_pkg::op_t pop_op,
	input  logic           pop_ready
);

	localparam int PW = vcsdm_pkg::PTR_W;
	localparam int CW = vcsdm_pkg::QCNT_W;

	vcsdm_pkg::op_t entry_q [vcsdm_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign push_ready = (cnt_q != CW'(vcsdm_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(vcsdm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(vcsdm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// ===== rtl/vcsdm_back.sv =====
`timescale 1ns / 1ps
// back end: block and light stores, dirty flags, neighbor marking and output register
// depends on vcsdm_pkg

module vcsdm_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  vcsdm_pkg::world_size_t               size,
	input  logic                                 pop_valid,
	input  vcsdm_pkg::op_t                       pop_op,
	output logic                                 pop_ready,
	output logic                                 clear_done,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// block_out, light_out, marked_chunk, dirty_out, zero fill
	output logic [vcsdm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// bounds_error, marked_valid
	output logic [vcsdm_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	output logic                                 m_axis_tlast
);

	localparam int AW = vcsdm_pkg::ADDR_W;
	localparam int B  = vcsdm_pkg::BLOCK_W;
	localparam int L  = vcsdm_pkg::LIGHT_W;
	localparam int CC = vcsdm_pkg::CC_W;
	localparam int LN = vcsdm_pkg::LIN_W;
	localparam int DW = vcsdm_pkg::DIRTY_W;

	vcsdm_pkg::bk_state_t state_q, state_d;
	logic [AW-1:0] clr_addr_q;

	logic [B-1:0] block_mem [vcsdm_pkg::STORE_DEPTH];
	logic [L-1:0] light_mem [vcsdm_pkg::STORE_DEPTH];
	logic [B-1:0] block_rd_q;
	logic [L-1:0] light_rd_q;
	vcsdm_pkg::op_kind_t rd_kind_q;

	logic [vcsdm_pkg::MAX_CHUNKS-1:0] dirty_q;

	vcsdm_pkg::axis_span_t span_x_q, span_y_q, span_z_q;
	logic ix_q, iy_q, iz_q;

	vcsdm_pkg::res_t out_q, res_d;
	logic out_valid_q;

	logic          o_free;
	logic          blk_we, lgt_we, mem_re;
	logic [AW-1:0] mem_waddr;
	logic [B-1:0]  blk_wdata;
	logic [L-1:0]  lgt_wdata;
	logic          res_load, mark_init, mark_step;

	logic [CC-1:0] ax, ay, az;
	logic [LN:0]   lin_full;
	logic [LN-1:0] mark_lin;
	logic [DW-1:0] mark_idx;
	logic          mark_in_map, mark_last;

	assign o_free     = !out_valid_q || m_axis_tready;
	assign clear_done = (state_q != vcsdm_pkg::BK_CLEAR);

	// chunk currently being marked
	assign ax = span_x_q.base + CC'(ix_q);
	assign ay = span_y_q.base + CC'(iy_q);
	assign az = span_z_q.base + CC'(iz_q);
	assign lin_full = (LN+1)'(int'(ax) + int'(size.nx) * (int'(ay) + int'(size.ny) * int'(az)));
	assign mark_lin    = lin_full[LN-1:0];
	assign mark_idx    = lin_full[DW-1:0];
	assign mark_in_map = (int'(lin_full) < vcsdm_pkg::MAX_CHUNKS);
	assign mark_last   = (ix_q == span_x_q.two) && (iy_q == span_y_q.two) && (iz_q == span_z_q.two);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vcsdm_pkg::BK_CLEAR: begin
				if (clr_addr_q == AW'(vcsdm_pkg::STORE_DEPTH - 1)) begin
					state_d = vcsdm_pkg::BK_IDLE;
				end
			end
			vcsdm_pkg::BK_IDLE: begin
				if (pop_valid) begin
					case (pop_op.kind)
						vcsdm_pkg::OP_GET_BLOCK, vcsdm_pkg::OP_GET_LIGHT: begin
							state_d = vcsdm_pkg::BK_READ;
						end
						vcsdm_pkg::OP_SET_BLOCK: begin
							state_d = vcsdm_pkg::BK_MARK;
						end
						default: begin
							state_d = vcsdm_pkg::BK_IDLE;
						end
					endcase
				end
			end
			vcsdm_pkg::BK_READ: begin
				if (o_free) begin
					state_d = vcsdm_pkg::BK_IDLE;
				end
			end
			vcsdm_pkg::BK_MARK: begin
				if (o_free && mark_last) begin
					state_d = vcsdm_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = vcsdm_pkg::BK_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		pop_ready = 1'b0;
		blk_we    = 1'b0;
		lgt_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = pop_op.addr;
		blk_wdata = pop_op.data;
		lgt_wdata = pop_op.data[L-1:0];
		res_load  = 1'b0;
		res_d     = '0;
		mark_init = 1'b0;
		mark_step = 1'b0;
		case (state_q)
			vcsdm_pkg::BK_CLEAR: begin
				blk_we    = 1'b1;
				lgt_we    = 1'b1;
				mem_waddr = clr_addr_q;
				blk_wdata = '0;
				lgt_wdata = '0;
			end
			vcsdm_pkg::BK_IDLE: begin
				if (pop_valid) begin
					case (pop_op.kind)
						vcsdm_pkg::OP_GET_BLOCK, vcsdm_pkg::OP_GET_LIGHT: begin
							mem_re    = 1'b1;
							pop_ready = 1'b1;
						end
						vcsdm_pkg::OP_SET_BLOCK: begin
							blk_we    = 1'b1;
							pop_ready = 1'b1;
							mark_init = 1'b1;
						end
						default: begin
							if (o_free) begin
								pop_ready  = 1'b1;
								res_load   = 1'b1;
								res_d.last = 1'b1;
								case (pop_op.kind)
									vcsdm_pkg::OP_SKY: begin
										res_d.light = L'(vcsdm_pkg::SKY_OPEN);
									end
									vcsdm_pkg::OP_SET_LIGHT: begin
										lgt_we = 1'b1;
									end
									vcsdm_pkg::OP_ERROR: begin
										res_d.bounds_error = 1'b1;
									end
									vcsdm_pkg::OP_DIRTY: begin
										res_d.dirty = pop_op.q_ok && dirty_q[pop_op.query[DW-1:0]];
									end
									default: begin
									end
								endcase
							end
						end
					endcase
				end
			end
			vcsdm_pkg::BK_READ: begin
				if (o_free) begin
					res_load   = 1'b1;
					res_d.last = 1'b1;
					if (rd_kind_q == vcsdm_pkg::OP_GET_BLOCK) begin
						res_d.block = block_rd_q;
					end else begin
						res_d.light = light_rd_q;
					end
				end
			end
			vcsdm_pkg::BK_MARK: begin
				if (o_free) begin
					res_load           = 1'b1;
					mark_step          = 1'b1;
					res_d.marked_valid = 1'b1;
					res_d.marked_chunk = mark_lin;
					res_d.last         = mark_last;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vcsdm_pkg::BK_CLEAR;
			clr_addr_q  <= '0;
			dirty_q     <= '1;
			out_valid_q <= 1'b0;
			span_x_q    <= '0;
			span_y_q    <= '0;
			span_z_q    <= '0;
			ix_q        <= 1'b0;
			iy_q        <= 1'b0;
			iz_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == vcsdm_pkg::BK_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (mark_step && mark_in_map) begin
				dirty_q[mark_idx] <= 1'b1;
			end
			if (mark_init) begin
				span_x_q <= pop_op.span_x;
				span_y_q <= pop_op.span_y;
				span_z_q <= pop_op.span_z;
				ix_q     <= 1'b0;
				iy_q     <= 1'b0;
				iz_q     <= 1'b0;
			end else if (mark_step) begin
				// dx runs fastest, then dy, then dz
				if (span_x_q.two && !ix_q) begin
					ix_q <= 1'b1;
				end else begin
					ix_q <= 1'b0;
					if (span_y_q.two && !iy_q) begin
						iy_q <= 1'b1;
					end else begin
						iy_q <= 1'b0;
						iz_q <= span_z_q.two && !iz_q;
					end
				end
			end
		end
	end

	// stores
	always_ff @(posedge clk) begin
		if (blk_we) begin
			block_mem[mem_waddr] <= blk_wdata;
		end
		if (mem_re) begin
			block_rd_q <= block_mem[pop_op.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (lgt_we) begin
			light_mem[mem_waddr] <= lgt_wdata;
		end
		if (mem_re) begin
			light_rd_q <= light_mem[pop_op.addr];
			rd_kind_q  <= pop_op.kind;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tuser  = {out_q.marked_valid, out_q.bounds_error};
	assign m_axis_tdata  = vcsdm_pkg::OUT_DATA_W'(
		{out_q.dirty, out_q.marked_chunk, out_q.light, out_q.block});

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vcsdm_pkg::BK_CLEAR) |-> !pop_ready)
		else $error("item taken during store clearing");

	assert property (@(posedge clk) disable iff (!arst_n)
		(mark_step && mark_in_map) |=> dirty_q[$past(mark_idx)])
		else $error("marked chunk not flagged dirty");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vcsdm_pkg::BK_MARK) |->
		((span_x_q.two || !ix_q) && (span_y_q.two || !iy_q) && (span_z_q.two || !iz_q)))
		else $error("neighbor walk left its span");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vcsdm_pkg::BK_IDLE && pop_valid &&
		(pop_op.kind == vcsdm_pkg::OP_GET_BLOCK || pop_op.kind == vcsdm_pkg::OP_GET_LIGHT))
		|=> (state_q == vcsdm_pkg::BK_READ))
		else $error("store read not followed by read state");

endmodule
